### hw/rtl/ihpn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the island height / Perlin noise pipeline.
// No dependencies.
package ihpn_pkg;

    typedef struct packed {
        logic [12:0] grid_width;
        logic [12:0] grid_height;
        logic [19:0] spacing;
        logic [23:0] noise_scale;
        logic [23:0] amplitude;
        logic [7:0]  seed;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_SPACING     = 3'd2,
        REG_NOISE_SCALE = 3'd3,
        REG_AMPLITUDE   = 3'd4,
        REG_SEED        = 3'd5
    } t_reg_idx;

    // stage counts of the sub-pipelines
    localparam int NOISE_LAT  = 6;
    localparam int RADIAL_LAT = 26;
    localparam int PIPE_LAT   = RADIAL_LAT + 1;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

endpackage

### hw/rtl/ihpn_noise.sv
`timescale 1ns / 1ps
// Six-stage 2D gradient noise pipeline: coordinate scaling, hashing, quintic fade, lerps.
// Depends on ihpn_pkg (t_cfg, PERM).
module ihpn_noise
    import ihpn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [11:0]         i_col,
    input  logic [11:0]         i_row,
    input  t_cfg                i_cfg,
    output logic signed [19:0]  o_noise
);

    function automatic logic signed [18:0] grad(input logic [2:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = h[2] ? 19'(y) : 19'(x);
        v = h[2] ? 19'(x) : 19'(y);
        grad = (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // a + floor(t*(b-a)/2^16)
    function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic [16:0] t);
        logic signed [20:0] d;
        logic signed [38:0] p;
        d = 21'(b) - 21'(a);
        p = 39'($signed({1'b0, t})) * 39'(d);
        lerp = a + $signed(p[35:16]);
    endfunction

    // stage 1
    logic [35:0] r_px, r_py;
    // stage 2
    logic [7:0]  r_pa, r_pb, r_yi;
    logic [15:0] r_xf2, r_yf2;
    logic [31:0] r_t2x, r_t2y;
    // stage 3
    logic [7:0]  r_aa, r_ab, r_ba, r_bb;
    logic [15:0] r_t3x, r_t3y, r_xf3, r_yf3;
    logic [19:0] r_qx, r_qy;
    // stage 4
    logic [16:0] r_u, r_v4;
    logic signed [18:0] r_gaa, r_gab, r_gba, r_gbb;
    // stage 5
    logic signed [19:0] r_x1, r_x2;
    logic [16:0] r_v5;
    // stage 6
    logic signed [19:0] r_noise;

    logic [7:0]  n_xi, n_yi;
    logic [31:0] n_m3x, n_m3y;
    logic [35:0] n_qx, n_qy, n_fx, n_fy;
    logic signed [17:0] n_x0, n_x1, n_y0, n_y1;

    always_comb begin
        n_xi  = r_px[23:16] + i_cfg.seed;
        n_yi  = r_py[23:16] + i_cfg.seed;
        n_m3x = r_t2x[31:16] * r_xf2;
        n_m3y = r_t2y[31:16] * r_yf2;
        n_qx  = 36'(r_t2x) * 36'd6 + 36'd42949672960 - 36'(r_xf2) * 36'd983040;
        n_qy  = 36'(r_t2y) * 36'd6 + 36'd42949672960 - 36'(r_yf2) * 36'd983040;
        n_fx  = 36'(r_t3x) * 36'(r_qx);
        n_fy  = 36'(r_t3y) * 36'(r_qy);
        // f and f-1 in signed Q.16
        n_x0  = $signed({2'b00, r_xf3});
        n_x1  = $signed({2'b11, r_xf3});
        n_y0  = $signed({2'b00, r_yf3});
        n_y1  = $signed({2'b11, r_yf3});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= 36'(i_col) * 36'(i_cfg.noise_scale);
            r_py   <= 36'(i_row) * 36'(i_cfg.noise_scale);

            r_pa   <= PERM[n_xi];
            r_pb   <= PERM[n_xi + 8'd1];
            r_yi   <= n_yi;
            r_xf2  <= r_px[15:0];
            r_yf2  <= r_py[15:0];
            r_t2x  <= 32'(r_px[15:0]) * 32'(r_px[15:0]);
            r_t2y  <= 32'(r_py[15:0]) * 32'(r_py[15:0]);

            r_aa   <= PERM[r_pa + r_yi];
            r_ab   <= PERM[r_pa + r_yi + 8'd1];
            r_ba   <= PERM[r_pb + r_yi];
            r_bb   <= PERM[r_pb + r_yi + 8'd1];
            r_t3x  <= n_m3x[31:16];
            r_t3y  <= n_m3y[31:16];
            r_qx   <= n_qx[35:16];
            r_qy   <= n_qy[35:16];
            r_xf3  <= r_xf2;
            r_yf3  <= r_yf2;

            r_u    <= n_fx[32:16];
            r_v4   <= n_fy[32:16];
            r_gaa  <= grad(r_aa[2:0], n_x0, n_y0);
            r_gba  <= grad(r_ba[2:0], n_x1, n_y0);
            r_gab  <= grad(r_ab[2:0], n_x0, n_y1);
            r_gbb  <= grad(r_bb[2:0], n_x1, n_y1);

            r_x1   <= lerp(20'(r_gaa), 20'(r_gba), r_u);
            r_x2   <= lerp(20'(r_gab), 20'(r_gbb), r_u);
            r_v5   <= r_v4;

            r_noise <= lerp(r_x1, r_x2, r_v5);
        end
    end

    assign o_noise = r_noise;

endmodule

### hw/rtl/ihpn_radial.sv
`timescale 1ns / 1ps
// Radial distance pipeline: normalised offsets by pipelined restoring division,
// squares, then a two-bits-per-stage integer square root. Depends on ihpn_pkg.
module ihpn_radial
    import ihpn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [11:0] i_col,
    input  logic [11:0] i_row,
    input  t_cfg        i_cfg,
    output logic [29:0] o_dist
);

    localparam int DIV_ST = 8;   // 4 quotient bits per stage, 32 in all
    localparam int SQ_ST  = 15;  // 2 root bits per stage, 30 in all

    function automatic logic [44:0] div4(input logic [12:0] rem_in,
                                         input logic [31:0] dq_in,
                                         input logic [12:0] n);
        logic [12:0] rem;
        logic [31:0] dq;
        logic [13:0] t;
        rem = rem_in;
        dq  = dq_in;
        for (int i = 0; i < 4; i++) begin
            t  = {rem, dq[31]};
            dq = {dq[30:0], 1'b0};
            if (t >= {1'b0, n}) begin
                rem   = 13'(t - {1'b0, n});
                dq[0] = 1'b1;
            end else begin
                rem = t[12:0];
            end
        end
        div4 = {rem, dq};
    endfunction

    function automatic logic [89:0] sqrt2(input logic [59:0] rem_in,
                                          input logic [29:0] root_in,
                                          input int khi);
        logic [59:0] rem;
        logic [29:0] root;
        logic [61:0] test;
        int k;
        rem  = rem_in;
        root = root_in;
        for (int i = 0; i < 2; i++) begin
            k    = khi - i;
            test = (62'(root) << (k + 1)) | (62'd1 << (2 * k));
            if (62'(rem) >= test) begin
                rem  = rem - 60'(test);
                root = root | (30'd1 << k);
            end
        end
        sqrt2 = {rem, root};
    endfunction

    logic [12:0] r_remx [DIV_ST+1];
    logic [12:0] r_remy [DIV_ST+1];
    logic [31:0] r_dqx  [DIV_ST+1];
    logic [31:0] r_dqy  [DIV_ST+1];
    logic [59:0] r_sqx, r_sqy;
    logic [59:0] r_srem [SQ_ST+1];
    logic [29:0] r_root [SQ_ST+1];

    logic [12:0] n_nw, n_nh;
    logic [13:0] n_c2, n_r2, n_ax, n_ay;
    logic [29:0] n_nx, n_ny;

    always_comb begin
        n_nw = (i_cfg.grid_width  == 13'd0) ? 13'd1 : i_cfg.grid_width;
        n_nh = (i_cfg.grid_height == 13'd0) ? 13'd1 : i_cfg.grid_height;
        n_c2 = {1'b0, i_col, 1'b0};
        n_r2 = {1'b0, i_row, 1'b0};
        n_ax = (n_c2 >= {1'b0, n_nw}) ? n_c2 - {1'b0, n_nw} : {1'b0, n_nw} - n_c2;
        n_ay = (n_r2 >= {1'b0, n_nh}) ? n_r2 - {1'b0, n_nh} : {1'b0, n_nh} - n_r2;
        // quotient stays below 2^30, so bits [29:0] hold all of it
        n_nx = r_dqx[DIV_ST][29:0];
        n_ny = r_dqy[DIV_ST][29:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // (a << 16) / (2n) taken as (a << 15) / n
            r_remx[0] <= '0;
            r_remy[0] <= '0;
            r_dqx[0]  <= {3'b000, n_ax, 15'd0};
            r_dqy[0]  <= {3'b000, n_ay, 15'd0};
            for (int s = 1; s <= DIV_ST; s++) begin
                {r_remx[s], r_dqx[s]} <= div4(r_remx[s-1], r_dqx[s-1], n_nw);
                {r_remy[s], r_dqy[s]} <= div4(r_remy[s-1], r_dqy[s-1], n_nh);
            end
            r_sqx     <= 60'(n_nx) * 60'(n_nx);
            r_sqy     <= 60'(n_ny) * 60'(n_ny);
            r_srem[0] <= r_sqx + r_sqy;
            r_root[0] <= '0;
            for (int s = 1; s <= SQ_ST; s++) begin
                {r_srem[s], r_root[s]} <= sqrt2(r_srem[s-1], r_root[s-1], 31 - 2 * s);
            end
        end
    end

    assign o_dist = r_root[SQ_ST];

endmodule

### hw/rtl/island_height_perlin_noise.sv
`timescale 1ns / 1ps
// Top level of the island vertex generator: config registers, stream handshake,
// position multipliers and height combine. Depends on ihpn_pkg, ihpn_noise, ihpn_radial.
//
// Usage:
//   s_axis carries one grid point per transaction: tdata = {row, column}, column in
//   the low 12 bits. m_axis returns one vertex per point, in order: tdata holds
//   pos_x [31:0], pos_y [63:32], height [89:64] (signed Q17.8), zeros above.
//   Configuration goes through i_cfg_we / i_cfg_addr / i_cfg_data, one register per
//   cycle, and must only be written while no points are in flight.
// Timing:
//   27 register stages from input to output transaction. One point is accepted
//   every cycle unless back-pressure holds the pipeline; the radial chain (offset
//   register, 8 divider stages, square, sum, 15 square-root stages) is 26 deep and
//   one more stage combines the height, which sets the depth.
// Reset:
//   Synchronous, active low. Registers return to their defaults (256x256 grid,
//   spacing 100.0, scale 0.1, amplitude 100.0, seed 0) and the pipeline empties.
// Back-pressure:
//   When m_axis_tready is low with a result pending, the whole pipeline freezes and
//   s_axis_tready drops; nothing is lost or repeated.
module island_height_perlin_noise
    import ihpn_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column [11:0], row [23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // pos_x [31:0], pos_y [63:32], height [89:64]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data
);

    localparam int          CB    = (COORD_BITS > 12) ? 12 : COORD_BITS;
    localparam logic [11:0] CMASK = 12'((32'd1 << CB) - 32'd1);
    localparam int          H1_ST = RADIAL_LAT - NOISE_LAT;

    t_cfg r_cfg;
    logic [PIPE_LAT-1:0] r_vld;
    logic [31:0] r_pos_x [PIPE_LAT];
    logic [31:0] r_pos_y [PIPE_LAT];
    logic signed [27:0] r_h1 [H1_ST];
    logic signed [25:0] r_height;

    logic en, accept;
    logic [11:0] col, row;
    logic signed [19:0] noise;
    logic [29:0] radial_dist;
    logic signed [44:0] n_h1p;
    logic signed [31:0] n_fall;
    logic signed [59:0] n_zp;
    logic signed [43:0] n_z;
    logic signed [25:0] n_height;

    assign en            = ~r_vld[PIPE_LAT-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid & en;
    assign col           = s_axis_tdata[11:0] & CMASK;
    assign row           = s_axis_tdata[23:12] & CMASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= 13'd256;
            r_cfg.grid_height <= 13'd256;
            r_cfg.spacing     <= 20'd25600;
            r_cfg.noise_scale <= 24'd6554;
            r_cfg.amplitude   <= 24'd25600;
            r_cfg.seed        <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg_data[12:0];
                REG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg_data[12:0];
                REG_SPACING:     r_cfg.spacing     <= i_cfg_data[19:0];
                REG_NOISE_SCALE: r_cfg.noise_scale <= i_cfg_data;
                REG_AMPLITUDE:   r_cfg.amplitude   <= i_cfg_data;
                REG_SEED:        r_cfg.seed        <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ihpn_noise u_noise (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_col   (col),
        .i_row   (row),
        .i_cfg   (r_cfg),
        .o_noise (noise)
    );

    ihpn_radial u_radial (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_col  (col),
        .i_row  (row),
        .i_cfg  (r_cfg),
        .o_dist (radial_dist)
    );

    always_comb begin
        n_h1p  = 45'(noise) * 45'($signed({1'b0, r_cfg.amplitude}));
        n_fall = 32'sd65536 - $signed({2'b00, radial_dist});
        n_zp   = 60'(r_h1[H1_ST-1]) * 60'(n_fall);
        n_z    = n_zp[59:16];
        if (n_z > 44'sd33554431) begin
            n_height = 26'sh1FFFFFF;
        end else if (n_z < -44'sd33554432) begin
            n_height = 26'sh2000000;
        end else begin
            n_height = n_z[25:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos_x[0] <= 32'(col) * 32'(r_cfg.spacing);
            r_pos_y[0] <= 32'(row) * 32'(r_cfg.spacing);
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_pos_x[i] <= r_pos_x[i-1];
                r_pos_y[i] <= r_pos_y[i-1];
            end
            r_h1[0] <= n_h1p[43:16];
            for (int i = 1; i < H1_ST; i++) begin
                r_h1[i] <= r_h1[i-1];
            end
            r_height <= n_height;
        end
    end

    assign m_axis_tvalid = r_vld[PIPE_LAT-1];
    assign m_axis_tdata  = {6'd0, r_height, r_pos_y[PIPE_LAT-1], r_pos_x[PIPE_LAT-1]};

endmodule
